@@ rtl/murmur3_32_stream_hash_macros.svh @@
// ----------------------------------------------------------------------------
// MurmurHash3 stream hasher assertion macros
// Concurrent checks, sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MURMUR3_32_STREAM_HASH_MACROS_SVH
`define MURMUR3_32_STREAM_HASH_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define M3H_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define M3H_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define M3H_ASSERT_SAME(lbl, ante, cons, msg)
`define M3H_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/m3h_pkg.sv @@
// ----------------------------------------------------------------------------
// MurmurHash3 stream hasher package
// Hash constants and the request type of the shared multiplier.
// ----------------------------------------------------------------------------
package m3h_pkg;

    // Block and finalizer constants of MurmurHash3 x86_32
    localparam logic [31:0] M3H_C1 = 32'hcc9e2d51;
    localparam logic [31:0] M3H_C2 = 32'h1b873593;
    localparam logic [31:0] M3H_N  = 32'he6546b64;
    localparam logic [31:0] M3H_F1 = 32'h85ebca6b;
    localparam logic [31:0] M3H_F2 = 32'hc2b2ae35;

    // Reset value of the seed register
    localparam logic [31:0] M3H_SEED_RESET = 32'h00000001;

    // Operand pair for the shared multiplier
    typedef struct packed {
        logic [31:0] op_a;
        logic [31:0] op_b;
    } m3h_mul_req_t;

endpackage

@@ rtl/m3h_mul.sv @@
// ----------------------------------------------------------------------------
// MurmurHash3 shared multiplier
// 32 x 32 multiply, low 32 bits of the product registered.
// ----------------------------------------------------------------------------
module m3h_mul (
    input  logic                 clk,
    input  m3h_pkg::m3h_mul_req_t req,
    output logic [31:0]          product
);
    import m3h_pkg::*;

    logic [31:0] product_reg;
    logic [31:0] product_next;

    // Form the low product word
    assign product_next = req.op_a * req.op_b;

    // Register the product
    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

@@ rtl/murmur3_32_stream_hash.sv @@
// ----------------------------------------------------------------------------
// MurmurHash3 x86_32 stream hasher
// Hashes a message fed one byte per request and emits the 32-bit hash.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        sink       in_valid / in_stall     data_byte, byte_valid, last
//  out       source     out_valid / out_stall   hash_value
//  seed      sink       seed_wr_en              seed_wr_data
//
//  A byte that does not complete a word is taken in the idle state. The byte
//  that completes a word runs the scramble steps SC1 to SC3: two multiplies in
//  the shared multiplier and the mix. A request with last runs the scramble of
//  the word or the leftover bytes (if any), then finalizer steps F1 to F3.
//  Asynchronous active-low reset loads seed 1 and clears the message state.
//  The next request is taken while a finished hash waits on out_stall; a
//  finished hash waits in the sequencer only while the output is still full.
// ----------------------------------------------------------------------------
module murmur3_32_stream_hash #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input requests
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last,
    // output requests
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value,
    // seed register
    input  logic        seed_wr_en,
    input  logic [31:0] seed_wr_data
);
    import m3h_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SC1,
        S_SC2,
        S_SC3,
        S_F1,
        S_F2,
        S_F3,
        S_OUT
    } state_t;

    state_t                 state_reg,    state_next;
    logic [31:0]            seed_reg,     seed_next;
    logic [31:0]            hash_reg,     hash_next;
    logic [23:0]            partial_reg,  partial_next;
    logic [1:0]             phase_reg,    phase_next;
    logic [COUNT_WIDTH-1:0] count_reg,    count_next;
    logic [31:0]            work_reg,     work_next;
    logic                   tail_reg,     tail_next;
    logic                   last_reg,     last_next;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_hash_reg, out_hash_next;

    m3h_mul_req_t mul_req;
    logic [31:0]  mul_product;
    logic         in_accept;
    logic         out_free;
    logic [31:0]  rot15;
    logic [31:0]  mix_rot;
    logic [31:0]  mix_hash;
    logic [31:0]  count_word;

    // Shared multiplier
    m3h_mul u_mul (
        .clk     (clk),
        .req     (mul_req),
        .product (mul_product)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign count_word = 32'(count_reg);

    // Rotates and the hash mix step
    assign rot15    = {mul_product[16:0], mul_product[31:17]};
    assign mix_rot  = {hash_reg[18:0] ^ mul_product[18:0],
                       hash_reg[31:19] ^ mul_product[31:19]};
    assign mix_hash = {mix_rot[29:0], 2'b00} + mix_rot + M3H_N;

    // Select multiplier operands by step
    always_comb
    begin
        mul_req.op_a = work_reg;
        mul_req.op_b = M3H_C1;
        case (state_reg)
            S_SC1:
            begin
                mul_req.op_a = work_reg;
                mul_req.op_b = M3H_C1;
            end
            S_SC2:
            begin
                mul_req.op_a = rot15;
                mul_req.op_b = M3H_C2;
            end
            S_F1:
            begin
                mul_req.op_a = work_reg ^ {16'h0000, work_reg[31:16]};
                mul_req.op_b = M3H_F1;
            end
            S_F2:
            begin
                mul_req.op_a = mul_product ^ {13'h0000, mul_product[31:13]};
                mul_req.op_b = M3H_F2;
            end
            default:
            begin
                mul_req.op_a = work_reg;
                mul_req.op_b = M3H_C1;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        hash_next      = hash_reg;
        partial_next   = partial_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        work_next      = work_reg;
        tail_next      = tail_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    last_next = last;
                    if (byte_valid)
                    begin
                        count_next = count_reg + COUNT_WIDTH'(1);
                        if (phase_reg == 2'd3)
                        begin
                            // Word complete: scramble and mix it
                            work_next  = {data_byte, partial_reg};
                            tail_next  = 1'b0;
                            state_next = S_SC1;
                        end
                        else
                        begin
                            partial_next = partial_reg;
                            case (phase_reg)
                                2'd0:    partial_next[7:0]   = data_byte;
                                2'd1:    partial_next[15:8]  = data_byte;
                                2'd2:    partial_next[23:16] = data_byte;
                                default: partial_next        = partial_reg;
                            endcase
                            phase_next = phase_reg + 2'd1;
                            if (last)
                            begin
                                // Leftover bytes: scramble the tail
                                work_next  = {8'h00, partial_next};
                                tail_next  = 1'b1;
                                state_next = S_SC1;
                            end
                        end
                    end
                    else if (last)
                    begin
                        if (phase_reg != 2'd0)
                        begin
                            work_next  = {8'h00, partial_reg};
                            tail_next  = 1'b1;
                            state_next = S_SC1;
                        end
                        else
                        begin
                            work_next  = hash_reg ^ count_word;
                            state_next = S_F1;
                        end
                    end
                end
            end
            S_SC1:
            begin
                state_next = S_SC2;
            end
            S_SC2:
            begin
                state_next = S_SC3;
            end
            S_SC3:
            begin
                if (tail_reg)
                begin
                    work_next  = hash_reg ^ mul_product ^ count_word;
                    state_next = S_F1;
                end
                else
                begin
                    hash_next    = mix_hash;
                    partial_next = '0;
                    phase_next   = 2'd0;
                    if (last_reg)
                    begin
                        work_next  = mix_hash ^ count_word;
                        state_next = S_F1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_F1:
            begin
                state_next = S_F2;
            end
            S_F2:
            begin
                state_next = S_F3;
            end
            S_F3:
            begin
                work_next  = mul_product ^ {16'h0000, mul_product[31:16]};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold until the output register is free, then reload the seed
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = work_reg;
                    hash_next      = seed_reg;
                    partial_next   = '0;
                    phase_next     = 2'd0;
                    count_next     = '0;
                    tail_next      = 1'b0;
                    last_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Seed write; a message not yet begun takes it at once
        if (seed_wr_en)
        begin
            seed_next = seed_wr_data;
            if ((count_reg == '0) && (phase_reg == 2'd0))
            begin
                hash_next = seed_wr_data;
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= M3H_SEED_RESET;
            hash_reg      <= M3H_SEED_RESET;
            partial_reg   <= '0;
            phase_reg     <= 2'd0;
            count_reg     <= '0;
            tail_reg      <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            hash_reg      <= hash_next;
            partial_reg   <= partial_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            tail_reg      <= tail_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        out_hash_reg <= out_hash_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;

`include "murmur3_32_stream_hash_macros.svh"

    // A closing request always leaves the idle state, toward scramble or finalizer
    `M3H_ASSERT_NEXT(a_last_busy, in_accept && last, in_stall, "last request did not finalize")

    // A byte that leaves a partial word keeps the input open
    `M3H_ASSERT_NEXT(a_byte_fast, in_accept && byte_valid && !last && (phase_reg != 2'd3), !in_stall, "partial byte stalled input")

    // Leftover bytes imply a nonzero count
    `M3H_ASSERT_SAME(a_phase_count, count_reg == '0, phase_reg == 2'd0, "phase set with zero count")

    // A result appears only from the output step
    `M3H_ASSERT_SAME(a_out_source, $rose(out_valid_reg), $past(state_reg) == S_OUT, "result outside output step")

endmodule
